[design/pps_pkg.sv]
// Shared constants, types and the control store of the previous-prime search core.
// Used by previous_prime_search_core; depends on nothing.
package pps_pkg;

  localparam int VALUE_BITS = 31;
  localparam int DATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int D_BITS     = (VALUE_BITS + 1) / 2 + 1;
  localparam int SQ_BITS    = VALUE_BITS + 2;
  localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
  localparam int STEP_BITS  = 5;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [DATA_BITS-1:0]  data_t;
  typedef logic [D_BITS-1:0]     div_t;
  typedef logic [SQ_BITS-1:0]    sq_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [STEP_BITS-1:0]  step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MAKE_ODD,
    OP_DIV3_START,
    OP_DIVD_START,
    OP_DIV_STEP,
    OP_ALIGN,
    OP_INIT_D,
    OP_NEXT_D,
    OP_NEXT_CAND,
    OP_SET_NONE,
    OP_SET_FIVE,
    OP_PUSH
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IN_IDLE,
    C_LIM_LT2,
    C_LIM_23,
    C_CAND_EQ3,
    C_CAND_LE5,
    C_DSQ_GT,
    C_DIV_BUSY,
    C_REM_ZERO,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  localparam step_t ST_CHECK_SMALL = 5'd0;
  localparam step_t ST_CHECK_23    = 5'd1;
  localparam step_t ST_MAKE_ODD    = 5'd2;
  localparam step_t ST_CHECK_3     = 5'd3;
  localparam step_t ST_MOD3_START  = 5'd4;
  localparam step_t ST_MOD3_RUN    = 5'd5;
  localparam step_t ST_ALIGN       = 5'd6;
  localparam step_t ST_CAND_LOOP   = 5'd7;
  localparam step_t ST_INIT_D      = 5'd8;
  localparam step_t ST_D_LOOP      = 5'd9;
  localparam step_t ST_MODD_START  = 5'd10;
  localparam step_t ST_MODD_RUN    = 5'd11;
  localparam step_t ST_TEST_REM    = 5'd12;
  localparam step_t ST_NEXT_D      = 5'd13;
  localparam step_t ST_NEXT_CAND   = 5'd14;
  localparam step_t ST_NONE        = 5'd15;
  localparam step_t ST_FIVE        = 5'd16;
  localparam step_t ST_PUSH_WAIT   = 5'd17;
  localparam step_t ST_PUSH        = 5'd18;
  localparam step_t ST_WAIT        = 5'd19;

  // step after ST_WAIT wraps to ST_CHECK_SMALL
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{op: OP_NOP, cond: C_NEVER, target: ST_WAIT};
    case (s)
      ST_CHECK_SMALL: w = '{op: OP_NOP,        cond: C_LIM_LT2,  target: ST_NONE};
      ST_CHECK_23:    w = '{op: OP_NOP,        cond: C_LIM_23,   target: ST_PUSH_WAIT};
      ST_MAKE_ODD:    w = '{op: OP_MAKE_ODD,   cond: C_NEVER,    target: ST_WAIT};
      ST_CHECK_3:     w = '{op: OP_NOP,        cond: C_CAND_EQ3, target: ST_PUSH_WAIT};
      ST_MOD3_START:  w = '{op: OP_DIV3_START, cond: C_NEVER,    target: ST_WAIT};
      ST_MOD3_RUN:    w = '{op: OP_DIV_STEP,   cond: C_DIV_BUSY, target: ST_MOD3_RUN};
      ST_ALIGN:       w = '{op: OP_ALIGN,      cond: C_NEVER,    target: ST_WAIT};
      ST_CAND_LOOP:   w = '{op: OP_NOP,        cond: C_CAND_LE5, target: ST_FIVE};
      ST_INIT_D:      w = '{op: OP_INIT_D,     cond: C_NEVER,    target: ST_WAIT};
      ST_D_LOOP:      w = '{op: OP_NOP,        cond: C_DSQ_GT,   target: ST_PUSH_WAIT};
      ST_MODD_START:  w = '{op: OP_DIVD_START, cond: C_NEVER,    target: ST_WAIT};
      ST_MODD_RUN:    w = '{op: OP_DIV_STEP,   cond: C_DIV_BUSY, target: ST_MODD_RUN};
      ST_TEST_REM:    w = '{op: OP_NOP,        cond: C_REM_ZERO, target: ST_NEXT_CAND};
      ST_NEXT_D:      w = '{op: OP_NEXT_D,     cond: C_ALWAYS,   target: ST_D_LOOP};
      ST_NEXT_CAND:   w = '{op: OP_NEXT_CAND,  cond: C_ALWAYS,   target: ST_CAND_LOOP};
      ST_NONE:        w = '{op: OP_SET_NONE,   cond: C_ALWAYS,   target: ST_PUSH_WAIT};
      ST_FIVE:        w = '{op: OP_SET_FIVE,   cond: C_NEVER,    target: ST_WAIT};
      ST_PUSH_WAIT:   w = '{op: OP_NOP,        cond: C_OUT_FULL, target: ST_PUSH_WAIT};
      ST_PUSH:        w = '{op: OP_PUSH,       cond: C_NEVER,    target: ST_WAIT};
      ST_WAIT:        w = '{op: OP_LOAD,       cond: C_IN_IDLE,  target: ST_WAIT};
      default:        w = '{op: OP_NOP,        cond: C_ALWAYS,   target: ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

[design/previous_prime_search_core.sv]
// Previous-prime search core: microcoded sequencer over a small arithmetic datapath.
// Depends on pps_pkg (control store, widths, types).
//
// Takes one limit at a time and returns the largest prime not above it, or
// zero with no_prime set when the limit is below two. One result register
// sits on the output, so the next limit is taken while a result still waits.
// The start value is first reduced mod 3, then every candidate above five is
// tested by trial division, both through one shared bit-serial remainder unit
// that loads its operands and then takes one cycle per dividend bit. Loop
// control for each trial division runs through ST_D_LOOP, ST_TEST_REM and
// ST_NEXT_D. Limits below 5 finish without any division. The worst case for
// 31-bit limits is set by the prime gap times the divisions up to the square
// root: a full-width prime alone needs about 23k divisions, and composites
// with large factors ahead of it add to that.
module previous_prime_search_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  pps_pkg::data_t         s_tdata,   // [VALUE_BITS-1:0] limit_value, rest zero
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output pps_pkg::data_t         m_tdata,   // [VALUE_BITS-1:0] prime_found, rest zero
  output logic                   m_tuser    // [0] no_prime
);

  pps_pkg::step_t  step;
  pps_pkg::step_t  step_next;
  pps_pkg::uword_t uw;
  logic            taken;

  pps_pkg::value_t lim;
  pps_pkg::value_t cand;
  logic            none_flag;
  logic            step4;
  pps_pkg::div_t   d;
  pps_pkg::sq_t    dsq;
  pps_pkg::value_t dvd;
  pps_pkg::value_t dvs;
  pps_pkg::value_t rem;
  pps_pkg::cnt_t   cnt;
  pps_pkg::value_t prime_out;
  logic            none_out;

  logic [pps_pkg::VALUE_BITS:0] shifted;
  logic [pps_pkg::VALUE_BITS:0] diff;
  logic                         out_full;
  logic                         load;
  logic                         push;

  assign uw       = pps_pkg::ucode(step);
  assign out_full = m_tvalid && !m_tready;
  assign s_tready = (step == pps_pkg::ST_WAIT);
  assign load     = s_tvalid && s_tready;
  assign push     = (uw.op == pps_pkg::OP_PUSH) && !out_full;

  assign shifted = {rem, dvd[pps_pkg::VALUE_BITS-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_comb begin
    unique case (uw.cond)
      pps_pkg::C_NEVER:    taken = 1'b0;
      pps_pkg::C_ALWAYS:   taken = 1'b1;
      pps_pkg::C_IN_IDLE:  taken = !s_tvalid;
      pps_pkg::C_LIM_LT2:  taken = (lim < pps_pkg::value_t'(2));
      pps_pkg::C_LIM_23:   taken = (lim == pps_pkg::value_t'(2)) ||
                                   (lim == pps_pkg::value_t'(3));
      pps_pkg::C_CAND_EQ3: taken = (cand == pps_pkg::value_t'(3));
      pps_pkg::C_CAND_LE5: taken = (cand <= pps_pkg::value_t'(5));
      pps_pkg::C_DSQ_GT:   taken = (dsq > pps_pkg::sq_t'(cand));
      pps_pkg::C_DIV_BUSY: taken = (cnt != pps_pkg::cnt_t'(1));
      pps_pkg::C_REM_ZERO: taken = (rem == '0);
      pps_pkg::C_OUT_FULL: taken = out_full;
      default:             taken = 1'b0;
    endcase
  end

  always_comb begin
    if (taken) begin
      step_next = uw.target;
    end else if (step == pps_pkg::ST_WAIT) begin
      step_next = pps_pkg::ST_CHECK_SMALL;
    end else begin
      step_next = step + pps_pkg::step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= pps_pkg::ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (uw.op)
      pps_pkg::OP_LOAD: begin
        if (load) begin
          lim       <= s_tdata[pps_pkg::VALUE_BITS-1:0];
          cand      <= s_tdata[pps_pkg::VALUE_BITS-1:0];
          none_flag <= 1'b0;
        end
      end
      pps_pkg::OP_MAKE_ODD: begin
        if (!cand[0]) begin
          cand <= cand - pps_pkg::value_t'(1);
        end
      end
      pps_pkg::OP_DIV3_START: begin
        dvd <= cand;
        dvs <= pps_pkg::value_t'(3);
        rem <= '0;
        cnt <= pps_pkg::cnt_t'(pps_pkg::VALUE_BITS);
      end
      pps_pkg::OP_DIVD_START: begin
        dvd <= cand;
        dvs <= pps_pkg::value_t'(d);
        rem <= '0;
        cnt <= pps_pkg::cnt_t'(pps_pkg::VALUE_BITS);
      end
      pps_pkg::OP_DIV_STEP: begin
        if (!diff[pps_pkg::VALUE_BITS]) begin
          rem <= diff[pps_pkg::VALUE_BITS-1:0];
        end else begin
          rem <= shifted[pps_pkg::VALUE_BITS-1:0];
        end
        dvd <= dvd << 1;
        cnt <= cnt - pps_pkg::cnt_t'(1);
      end
      pps_pkg::OP_ALIGN: begin
        // wheel: 1 mod 6 steps down by 2, 5 mod 6 by 4
        if (rem == '0) begin
          cand  <= cand - pps_pkg::value_t'(2);
          step4 <= 1'b0;
        end else begin
          step4 <= rem[1];
        end
      end
      pps_pkg::OP_INIT_D: begin
        d   <= pps_pkg::div_t'(5);
        dsq <= pps_pkg::sq_t'(25);
      end
      pps_pkg::OP_NEXT_D: begin
        d   <= d + pps_pkg::div_t'(2);
        dsq <= dsq + pps_pkg::sq_t'({d, 2'b00}) + pps_pkg::sq_t'(4);
      end
      pps_pkg::OP_NEXT_CAND: begin
        cand  <= cand - (step4 ? pps_pkg::value_t'(4) : pps_pkg::value_t'(2));
        step4 <= !step4;
      end
      pps_pkg::OP_SET_NONE: begin
        cand      <= '0;
        none_flag <= 1'b1;
      end
      pps_pkg::OP_SET_FIVE: begin
        cand <= pps_pkg::value_t'(5);
      end
      pps_pkg::OP_PUSH: begin
        if (push) begin
          prime_out <= cand;
          none_out  <= none_flag;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = pps_pkg::data_t'(prime_out);
  assign m_tuser = none_out;

endmodule
